/* sv/pcf_pkg.sv */
`default_nettype none
package pcf_pkg;
  localparam int MAX_POINTS = 64;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 26;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SQ_W       = PROD_W + 1;
  localparam int SUM_W      = COORD_W + PT_AW;
  localparam int NUM_W      = SUM_W + 1;
  localparam int DEN_W      = CNT_W + 1;
  localparam int DIV_STEP_W = $clog2(NUM_W);
  localparam int MD_W       = 16;
  localparam int REACH_W    = MD_W + 1;
  localparam int REACH2_W   = 2 * REACH_W;
  localparam int LIM2_W     = 2 * MD_W;
  localparam int MC_W       = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CLOSE_LIMIT = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 1'b1;

  localparam logic [MD_W-1:0] MAX_DIST_RST  = 16'd128;
  localparam logic [MC_W-1:0] MIN_COUNT_RST = 7'd4;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_INIT, ST_I_RD, ST_I_LD,
    ST_P1_RD, ST_P1_SQ, ST_P1_WAIT, ST_P1_END,
    ST_DIVX, ST_DIVX_W, ST_DIVZ, ST_DIVZ_W,
    ST_P2_RD, ST_P2_SQ, ST_P2_WAIT,
    ST_P3_RD, ST_P3_CMP, ST_NEXT_I,
    ST_EM_RD, ST_EM_LD, ST_EM_HOLD
  } state_t;
endpackage
`default_nettype wire

/* sv/pcf_if.sv */
`default_nettype none
interface pcf_pt_if;
  logic            valid;
  logic            ready;
  pcf_pkg::coord_t point_x;
  pcf_pkg::coord_t point_z;
  logic            last_point;
  modport source (output valid, point_x, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_z, last_point, output ready);
endinterface

interface pcf_ctr_if;
  logic            valid;
  logic            ready;
  pcf_pkg::coord_t centre_x;
  pcf_pkg::coord_t centre_z;
  logic            centre_valid;
  logic            last_centre;
  logic            points_dropped;
  modport source (output valid, centre_x, centre_z, centre_valid, last_centre,
                  points_dropped, input ready);
  modport sink   (input valid, centre_x, centre_z, centre_valid, last_centre,
                  points_dropped, output ready);
endinterface
`default_nettype wire

/* sv/pcf_sqdist.sv */
`default_nettype none
module pcf_sqdist (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire pcf_pkg::coord_t             ax,
  input  wire pcf_pkg::coord_t             az,
  input  wire pcf_pkg::coord_t             bx,
  input  wire pcf_pkg::coord_t             bz,
  output logic                             done,
  output logic [pcf_pkg::SQ_W-1:0]         sq
);
  logic signed [pcf_pkg::DIFF_W-1:0] dx, dz;
  logic [pcf_pkg::DIFF_W-1:0]        absx_r, absz_r, mul_op;
  logic [pcf_pkg::PROD_W-1:0]        prod, px_r, pz_r;
  logic                              v1_r, v2_r, v3_r;
  logic [pcf_pkg::SQ_W-1:0]          sq_r;
  logic                              done_r;

  function automatic logic [pcf_pkg::DIFF_W-1:0] DIFF_W_neg(
      input logic [pcf_pkg::DIFF_W-1:0] v);
    return ~v + 1'b1;
  endfunction

  assign dx = pcf_pkg::DIFF_W'(ax) - pcf_pkg::DIFF_W'(bx);
  assign dz = pcf_pkg::DIFF_W'(az) - pcf_pkg::DIFF_W'(bz);

  // one shared multiplier: x on the first step, z on the second
  assign mul_op = v1_r ? absx_r : absz_r;
  assign prod   = pcf_pkg::PROD_W'(mul_op) * pcf_pkg::PROD_W'(mul_op);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      absx_r <= dx[pcf_pkg::DIFF_W-1] ? DIFF_W_neg(dx) : dx;
      absz_r <= dz[pcf_pkg::DIFF_W-1] ? DIFF_W_neg(dz) : dz;
    end
    if (v1_r) px_r <= prod;
    if (v2_r) pz_r <= prod;
    if (v3_r) sq_r <= pcf_pkg::SQ_W'(px_r) + pcf_pkg::SQ_W'(pz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else        done_r <= v3_r;
  end

  assign done = done_r;
  assign sq   = sq_r;
endmodule
`default_nettype wire

/* sv/pcf_divider.sv */
`default_nettype none
module pcf_divider (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [pcf_pkg::SUM_W-1:0] sum_i,
  input  wire logic [pcf_pkg::CNT_W-1:0]        cnt_i,
  output logic                                  done,
  output pcf_pkg::coord_t                       mean_o
);
  logic [pcf_pkg::SUM_W-1:0]      abs_sum;
  logic [pcf_pkg::NUM_W-1:0]      numer, num_r;
  logic [pcf_pkg::DEN_W-1:0]      den_r;
  logic [pcf_pkg::DEN_W-1:0]      rem_r;
  logic [pcf_pkg::DEN_W:0]        rem_sh, rem_new;
  logic                           ge;
  logic                           neg_r, busy_r, done_r;
  logic [pcf_pkg::DIV_STEP_W-1:0] step_r;
  logic [pcf_pkg::NUM_W-1:0]      q_fin;
  pcf_pkg::coord_t                mean_r;

  assign abs_sum = sum_i[pcf_pkg::SUM_W-1] ? (~sum_i + 1'b1) : sum_i;
  // round half away from zero: (2|s| + n) / (2n)
  assign numer   = {abs_sum, 1'b0} + pcf_pkg::NUM_W'(cnt_i);

  assign rem_sh  = {rem_r, num_r[pcf_pkg::NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_new = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  assign q_fin   = {num_r[pcf_pkg::NUM_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == pcf_pkg::DIV_STEP_W'(pcf_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      den_r <= {cnt_i, 1'b0};
      rem_r <= '0;
      neg_r <= sum_i[pcf_pkg::SUM_W-1];
    end else if (busy_r) begin
      num_r <= q_fin;
      rem_r <= rem_new[pcf_pkg::DEN_W-1:0];
      if (step_r == pcf_pkg::DIV_STEP_W'(pcf_pkg::NUM_W - 1)) begin
        mean_r <= neg_r ? (~q_fin[pcf_pkg::COORD_W-1:0] + 1'b1)
                        : q_fin[pcf_pkg::COORD_W-1:0];
      end
    end
  end

  assign done   = done_r;
  assign mean_o = mean_r;
endmodule
`default_nettype wire

/* sv/point_cluster_finder_unit.sv */
// Load: one point per cycle while ready, up to MAX_POINTS stored.
// Pass after the last point, per stored point i: gather points within 2*max_dist
//   (squared-distance unit); with enough gathered, take the mean (33-step divider),
//   check all gathered within max_dist of it, keep it unless close to a kept one.
// Results: each held through downstream stall; next set loads afterwards.
// Reset (synchronous, rst_n low): empty set, registers to 128 and 4.
`default_nettype none
module point_cluster_finder_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [pcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pcf_pkg::MD_W-1:0]          cfg_data,
  pcf_pt_if.sink                                 in_pt,
  pcf_ctr_if.source                              out_ctr
);
  pcf_pkg::state_t state_r, state_nxt;

  logic [pcf_pkg::MD_W-1:0]     max_dist_r;
  logic [pcf_pkg::MC_W-1:0]     min_count_r;
  logic [pcf_pkg::CNT_W-1:0]    cnt_r, cnt_nxt, kept_cnt_r, kept_cnt_nxt;
  logic [pcf_pkg::CNT_W-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, n_r, n_nxt;
  logic                         ovf_r, ovf_nxt;
  pcf_pkg::coord_t              pix_r, pix_nxt, piz_r, piz_nxt;
  pcf_pkg::coord_t              pjx_r, pjx_nxt, pjz_r, pjz_nxt;
  pcf_pkg::coord_t              mx_r, mx_nxt, mz_r, mz_nxt;
  logic signed [pcf_pkg::SUM_W-1:0] sx_r, sx_nxt, sz_r, sz_nxt;
  logic [pcf_pkg::REACH2_W-1:0] reach2_r, reach2_nxt;
  logic [pcf_pkg::LIM2_W-1:0]   lim2_r, lim2_nxt;
  logic [pcf_pkg::REACH_W-1:0]  reach;

  logic                         ovalid_r, ovalid_nxt;
  pcf_pkg::coord_t              ox_r, ox_nxt, oz_r, oz_nxt;
  logic                         ocv_r, ocv_nxt, olast_r, olast_nxt, odrop_r, odrop_nxt;

  pcf_pkg::coord_t              pt_mem_x [pcf_pkg::MAX_POINTS];
  pcf_pkg::coord_t              pt_mem_z [pcf_pkg::MAX_POINTS];
  pcf_pkg::coord_t              kept_mem_x [pcf_pkg::MAX_POINTS];
  pcf_pkg::coord_t              kept_mem_z [pcf_pkg::MAX_POINTS];
  logic                         mark_mem [pcf_pkg::MAX_POINTS];
  pcf_pkg::coord_t              pt_rd_x, pt_rd_z, kept_rd_x, kept_rd_z;
  logic                         mark_rd;
  logic [pcf_pkg::PT_AW-1:0]    pt_ra, kept_ra;
  logic                         pt_we, kept_we, mark_we, mark_wd;

  logic                         sq_start, sq_done;
  pcf_pkg::coord_t              sq_ax, sq_az;
  logic [pcf_pkg::SQ_W-1:0]     sq;
  logic                         div_start, div_done;
  logic signed [pcf_pkg::SUM_W-1:0] div_sum;
  pcf_pkg::coord_t              div_mean;
  logic                         in_xfer, out_xfer, close;
  logic signed [pcf_pkg::DIFF_W-1:0] cdx, cdz;

  pcf_sqdist u_sqdist (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .ax(sq_ax), .az(sq_az), .bx(pt_rd_x), .bz(pt_rd_z),
    .done(sq_done), .sq(sq)
  );

  pcf_divider u_divider (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .sum_i(div_sum), .cnt_i(n_r), .done(div_done), .mean_o(div_mean)
  );

  assign in_pt.ready  = (state_r == pcf_pkg::ST_LOAD);
  assign in_xfer      = in_pt.valid && in_pt.ready;
  assign out_xfer     = ovalid_r && out_ctr.ready;
  assign reach        = {max_dist_r, 1'b0};

  assign cdx   = pcf_pkg::DIFF_W'(kept_rd_x) - pcf_pkg::DIFF_W'(mx_r);
  assign cdz   = pcf_pkg::DIFF_W'(kept_rd_z) - pcf_pkg::DIFF_W'(mz_r);
  assign close = (cdx > -pcf_pkg::DIFF_W'(pcf_pkg::CLOSE_LIMIT))
              && (cdx <  pcf_pkg::DIFF_W'(pcf_pkg::CLOSE_LIMIT))
              && (cdz > -pcf_pkg::DIFF_W'(pcf_pkg::CLOSE_LIMIT))
              && (cdz <  pcf_pkg::DIFF_W'(pcf_pkg::CLOSE_LIMIT));

  assign out_ctr.valid          = ovalid_r;
  assign out_ctr.centre_x       = ox_r;
  assign out_ctr.centre_z       = oz_r;
  assign out_ctr.centre_valid   = ocv_r;
  assign out_ctr.last_centre    = olast_r;
  assign out_ctr.points_dropped = odrop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r  <= pcf_pkg::MAX_DIST_RST;
      min_count_r <= pcf_pkg::MIN_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcf_pkg::CFG_MAX_DIST:  max_dist_r  <= cfg_data;
        pcf_pkg::CFG_MIN_COUNT: min_count_r <= cfg_data[pcf_pkg::MC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem_x[cnt_r[pcf_pkg::PT_AW-1:0]] <= in_pt.point_x;
      pt_mem_z[cnt_r[pcf_pkg::PT_AW-1:0]] <= in_pt.point_z;
    end
    pt_rd_x <= pt_mem_x[pt_ra];
    pt_rd_z <= pt_mem_z[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (kept_we) begin
      kept_mem_x[kept_cnt_r[pcf_pkg::PT_AW-1:0]] <= mx_r;
      kept_mem_z[kept_cnt_r[pcf_pkg::PT_AW-1:0]] <= mz_r;
    end
    kept_rd_x <= kept_mem_x[kept_ra];
    kept_rd_z <= kept_mem_z[kept_ra];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[j_r[pcf_pkg::PT_AW-1:0]] <= mark_wd;
    mark_rd <= mark_mem[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pcf_pkg::ST_LOAD;
      cnt_r      <= '0;
      kept_cnt_r <= '0;
      ovf_r      <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      kept_cnt_r <= kept_cnt_nxt;
      ovf_r      <= ovf_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    n_r      <= n_nxt;
    pix_r    <= pix_nxt;
    piz_r    <= piz_nxt;
    pjx_r    <= pjx_nxt;
    pjz_r    <= pjz_nxt;
    mx_r     <= mx_nxt;
    mz_r     <= mz_nxt;
    sx_r     <= sx_nxt;
    sz_r     <= sz_nxt;
    reach2_r <= reach2_nxt;
    lim2_r   <= lim2_nxt;
    ox_r     <= ox_nxt;
    oz_r     <= oz_nxt;
    ocv_r    <= ocv_nxt;
    olast_r  <= olast_nxt;
    odrop_r  <= odrop_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    kept_cnt_nxt = kept_cnt_r;
    ovf_nxt      = ovf_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    n_nxt        = n_r;
    pix_nxt      = pix_r;
    piz_nxt      = piz_r;
    pjx_nxt      = pjx_r;
    pjz_nxt      = pjz_r;
    mx_nxt       = mx_r;
    mz_nxt       = mz_r;
    sx_nxt       = sx_r;
    sz_nxt       = sz_r;
    reach2_nxt   = reach2_r;
    lim2_nxt     = lim2_r;
    ovalid_nxt   = ovalid_r;
    ox_nxt       = ox_r;
    oz_nxt       = oz_r;
    ocv_nxt      = ocv_r;
    olast_nxt    = olast_r;
    odrop_nxt    = odrop_r;
    pt_we        = 1'b0;
    kept_we      = 1'b0;
    mark_we      = 1'b0;
    mark_wd      = 1'b0;
    pt_ra        = j_r[pcf_pkg::PT_AW-1:0];
    kept_ra      = k_r[pcf_pkg::PT_AW-1:0];
    sq_start     = 1'b0;
    sq_ax        = pix_r;
    sq_az        = piz_r;
    div_start    = 1'b0;
    div_sum      = sx_r;

    unique case (state_r)
      pcf_pkg::ST_LOAD: begin
        if (in_xfer) begin
          if (cnt_r < pcf_pkg::CNT_W'(pcf_pkg::MAX_POINTS)) begin
            pt_we   = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_pt.last_point) state_nxt = pcf_pkg::ST_INIT;
        end
      end
      pcf_pkg::ST_INIT: begin
        reach2_nxt   = pcf_pkg::REACH2_W'(reach) * pcf_pkg::REACH2_W'(reach);
        lim2_nxt     = pcf_pkg::LIM2_W'(max_dist_r) * pcf_pkg::LIM2_W'(max_dist_r);
        kept_cnt_nxt = '0;
        i_nxt        = '0;
        state_nxt    = pcf_pkg::ST_I_RD;
      end
      pcf_pkg::ST_I_RD: begin
        pt_ra     = i_r[pcf_pkg::PT_AW-1:0];
        state_nxt = pcf_pkg::ST_I_LD;
      end
      pcf_pkg::ST_I_LD: begin
        pix_nxt   = pt_rd_x;
        piz_nxt   = pt_rd_z;
        j_nxt     = '0;
        n_nxt     = '0;
        sx_nxt    = '0;
        sz_nxt    = '0;
        state_nxt = pcf_pkg::ST_P1_RD;
      end
      pcf_pkg::ST_P1_RD: begin
        state_nxt = pcf_pkg::ST_P1_SQ;
      end
      pcf_pkg::ST_P1_SQ: begin
        sq_start  = 1'b1;
        pjx_nxt   = pt_rd_x;
        pjz_nxt   = pt_rd_z;
        state_nxt = pcf_pkg::ST_P1_WAIT;
      end
      pcf_pkg::ST_P1_WAIT: begin
        if (sq_done) begin
          mark_we = 1'b1;
          mark_wd = (sq <= pcf_pkg::SQ_W'(reach2_r));
          if (mark_wd) begin
            sx_nxt = sx_r + pcf_pkg::SUM_W'(pjx_r);
            sz_nxt = sz_r + pcf_pkg::SUM_W'(pjz_r);
            n_nxt  = n_r + 1'b1;
          end
          if (j_r + 1'b1 == cnt_r) begin
            state_nxt = pcf_pkg::ST_P1_END;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = pcf_pkg::ST_P1_RD;
          end
        end
      end
      pcf_pkg::ST_P1_END: begin
        if (n_r == '0 || n_r < pcf_pkg::CNT_W'(min_count_r)) begin
          state_nxt = pcf_pkg::ST_NEXT_I;
        end else begin
          state_nxt = pcf_pkg::ST_DIVX;
        end
      end
      pcf_pkg::ST_DIVX: begin
        div_start = 1'b1;
        state_nxt = pcf_pkg::ST_DIVX_W;
      end
      pcf_pkg::ST_DIVX_W: begin
        if (div_done) begin
          mx_nxt    = div_mean;
          state_nxt = pcf_pkg::ST_DIVZ;
        end
      end
      pcf_pkg::ST_DIVZ: begin
        div_sum   = sz_r;
        div_start = 1'b1;
        state_nxt = pcf_pkg::ST_DIVZ_W;
      end
      pcf_pkg::ST_DIVZ_W: begin
        if (div_done) begin
          mz_nxt    = div_mean;
          j_nxt     = '0;
          state_nxt = pcf_pkg::ST_P2_RD;
        end
      end
      pcf_pkg::ST_P2_RD: begin
        state_nxt = pcf_pkg::ST_P2_SQ;
      end
      pcf_pkg::ST_P2_SQ: begin
        sq_ax = mx_r;
        sq_az = mz_r;
        if (mark_rd) begin
          sq_start  = 1'b1;
          state_nxt = pcf_pkg::ST_P2_WAIT;
        end else if (j_r + 1'b1 == cnt_r) begin
          k_nxt     = '0;
          state_nxt = pcf_pkg::ST_P3_RD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = pcf_pkg::ST_P2_RD;
        end
      end
      pcf_pkg::ST_P2_WAIT: begin
        if (sq_done) begin
          if (sq > pcf_pkg::SQ_W'(lim2_r)) begin
            state_nxt = pcf_pkg::ST_NEXT_I;
          end else if (j_r + 1'b1 == cnt_r) begin
            k_nxt     = '0;
            state_nxt = pcf_pkg::ST_P3_RD;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = pcf_pkg::ST_P2_RD;
          end
        end
      end
      pcf_pkg::ST_P3_RD: begin
        if (k_r == kept_cnt_r) begin
          if (kept_cnt_r < pcf_pkg::CNT_W'(pcf_pkg::MAX_POINTS)) begin
            kept_we      = 1'b1;
            kept_cnt_nxt = kept_cnt_r + 1'b1;
          end
          state_nxt = pcf_pkg::ST_NEXT_I;
        end else begin
          state_nxt = pcf_pkg::ST_P3_CMP;
        end
      end
      pcf_pkg::ST_P3_CMP: begin
        if (close) begin
          state_nxt = pcf_pkg::ST_NEXT_I;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = pcf_pkg::ST_P3_RD;
        end
      end
      pcf_pkg::ST_NEXT_I: begin
        if (i_r + 1'b1 == cnt_r) begin
          k_nxt     = '0;
          state_nxt = pcf_pkg::ST_EM_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = pcf_pkg::ST_I_RD;
        end
      end
      pcf_pkg::ST_EM_RD: begin
        if (kept_cnt_r == '0) begin
          ovalid_nxt = 1'b1;
          ox_nxt     = '0;
          oz_nxt     = '0;
          ocv_nxt    = 1'b0;
          olast_nxt  = 1'b1;
          odrop_nxt  = ovf_r;
          state_nxt  = pcf_pkg::ST_EM_HOLD;
        end else begin
          state_nxt = pcf_pkg::ST_EM_LD;
        end
      end
      pcf_pkg::ST_EM_LD: begin
        ovalid_nxt = 1'b1;
        ox_nxt     = kept_rd_x;
        oz_nxt     = kept_rd_z;
        ocv_nxt    = 1'b1;
        olast_nxt  = (k_r + 1'b1 == kept_cnt_r);
        odrop_nxt  = ovf_r;
        state_nxt  = pcf_pkg::ST_EM_HOLD;
      end
      pcf_pkg::ST_EM_HOLD: begin
        if (out_xfer) begin
          ovalid_nxt = 1'b0;
          if (olast_r) begin
            cnt_nxt      = '0;
            ovf_nxt      = 1'b0;
            kept_cnt_nxt = '0;
            state_nxt    = pcf_pkg::ST_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = pcf_pkg::ST_EM_RD;
          end
        end
      end
      default: state_nxt = pcf_pkg::ST_LOAD;
    endcase
  end
endmodule
`default_nettype wire

/* sv/pcf_checker.sv */
`default_nettype none
module pcf_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            in_last,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire pcf_pkg::coord_t out_x,
  input wire pcf_pkg::coord_t out_z,
  input wire logic            out_cv,
  input wire logic            out_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_z))
    else $error("stalled result changed");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cv |-> out_last && out_x == '0 && out_z == '0)
    else $error("empty marker malformed");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("ready right after last point");
endmodule

bind point_cluster_finder_unit pcf_checker u_pcf_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_pt.valid), .in_ready(in_pt.ready), .in_last(in_pt.last_point),
  .out_valid(out_ctr.valid), .out_ready(out_ctr.ready),
  .out_x(out_ctr.centre_x), .out_z(out_ctr.centre_z),
  .out_cv(out_ctr.centre_valid), .out_last(out_ctr.last_centre)
);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    pcf_pkg::coord_t cx;
    pcf_pkg::coord_t cz;
    bit     cvalid;
    bit     clast;
    bit     dropped;
  } centre_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pcf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pcf_pkg::MD_W-1:0] cfg_data;

  pcf_pt_if  pt_bus ();
  pcf_ctr_if ctr_bus ();

  point_cluster_finder_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_pt(pt_bus.sink), .out_ctr(ctr_bus.source)
  );

  // predictor state
  longint set_x [pcf_pkg::MAX_POINTS];
  longint set_z [pcf_pkg::MAX_POINTS];
  int     set_cnt;
  bit     set_ovf;
  longint cur_max_dist;
  longint cur_min_count;
  centre_t centre_q[$];

  int errors;
  int idle_pct;
  int sink_idle_pct;
  int hold_cycles;

  always #5 clk = ~clk;

  function automatic longint round_avg(longint s, longint n);
    if (s >= 0) return (2 * s + n) / (2 * n);
    return -((2 * -s + n) / (2 * n));
  endfunction

  function automatic longint dist2(longint ax, longint az, longint bx, longint bz);
    return (ax - bx) * (ax - bx) + (az - bz) * (az - bz);
  endfunction

  function automatic void predict_centres();
    longint reach2, lim2, sx, sz, mx, mz, n;
    longint kx [pcf_pkg::MAX_POINTS];
    longint kz [pcf_pkg::MAX_POINTS];
    bit mark [pcf_pkg::MAX_POINTS];
    int kc;
    bit ok, dup;
    centre_t c;
    reach2 = 4 * cur_max_dist * cur_max_dist;
    lim2 = cur_max_dist * cur_max_dist;
    kc = 0;
    for (int i = 0; i < set_cnt; i++) begin
      sx = 0; sz = 0; n = 0; ok = 1; dup = 0;
      for (int j = 0; j < set_cnt; j++) begin
        mark[j] = dist2(set_x[i], set_z[i], set_x[j], set_z[j]) <= reach2;
        if (mark[j]) begin
          sx += set_x[j]; sz += set_z[j]; n++;
        end
      end
      if (n == 0 || n < cur_min_count) continue;
      mx = round_avg(sx, n);
      mz = round_avg(sz, n);
      for (int j = 0; j < set_cnt; j++)
        if (mark[j] && dist2(mx, mz, set_x[j], set_z[j]) > lim2) ok = 0;
      if (!ok) continue;
      for (int k = 0; k < kc; k++)
        if ((kx[k] - mx < 16) && (mx - kx[k] < 16) &&
            (kz[k] - mz < 16) && (mz - kz[k] < 16)) dup = 1;
      if (!dup && kc < pcf_pkg::MAX_POINTS) begin
        kx[kc] = mx; kz[kc] = mz; kc++;
      end
    end
    if (kc == 0) begin
      c.cx = '0; c.cz = '0; c.cvalid = 0; c.clast = 1; c.dropped = set_ovf;
      centre_q = {centre_q, c};
    end
    for (int k = 0; k < kc; k++) begin
      c.cx = pcf_pkg::coord_t'(kx[k]); c.cz = pcf_pkg::coord_t'(kz[k]);
      c.cvalid = 1; c.clast = (k == kc - 1); c.dropped = set_ovf;
      centre_q = {centre_q, c};
    end
    set_cnt = 0;
    set_ovf = 0;
  endfunction

  task automatic send_point(longint x, longint z, bit last);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      pt_bus.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    pt_bus.valid      <= 1'b1;
    pt_bus.point_x    <= pcf_pkg::coord_t'(x);
    pt_bus.point_z    <= pcf_pkg::coord_t'(z);
    pt_bus.last_point <= last;
    do @(posedge clk); while (!pt_bus.ready);
    if (set_cnt < pcf_pkg::MAX_POINTS) begin
      set_x[set_cnt] = longint'(pcf_pkg::coord_t'(x));
      set_z[set_cnt] = longint'(pcf_pkg::coord_t'(z));
      set_cnt++;
    end else
      set_ovf = 1;
    if (last) predict_centres();
  endtask

  task automatic wait_drain();
    pt_bus.valid <= 1'b0;
    while (centre_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [pcf_pkg::CFG_IDX_W-1:0] idx, longint val);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[pcf_pkg::MD_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pcf_pkg::CFG_MAX_DIST) cur_max_dist = val & 16'hFFFF;
    else cur_min_count = val & 7'h7F;
  endtask

  function automatic longint rand_coord();
    return longint'(pcf_pkg::coord_t'($urandom));
  endfunction

  // cluster of n points around a centre, spread within +-sp
  task automatic send_blob(int n, int sp, bit last);
    longint cx, cz;
    cx = rand_coord();
    cz = rand_coord();
    if (cx > 33000000) cx = 33000000;
    if (cx < -33000000) cx = -33000000;
    if (cz > 33000000) cz = 33000000;
    if (cz < -33000000) cz = -33000000;
    for (int i = 0; i < n; i++)
      send_point(cx + $urandom_range(2 * sp) - sp, cz + $urandom_range(2 * sp) - sp,
                 last && i == n - 1);
  endtask

  // checker
  always @(posedge clk) begin
    centre_t e;
    if (rst_n && ctr_bus.valid && ctr_bus.ready) begin
      if (centre_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected centre transfer x=%0d z=%0d",
                                   ctr_bus.centre_x, ctr_bus.centre_z);
      end else begin
        e = centre_q.pop_front();
        if (ctr_bus.centre_x !== e.cx || ctr_bus.centre_z !== e.cz ||
            ctr_bus.centre_valid !== e.cvalid || ctr_bus.last_centre !== e.clast ||
            ctr_bus.points_dropped !== e.dropped) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp x=%0d z=%0d v=%0b l=%0b d=%0b",
                     e.cx, e.cz, e.cvalid, e.clast, e.dropped,
                     " got x=%0d z=%0d v=%0b l=%0b d=%0b",
                     ctr_bus.centre_x, ctr_bus.centre_z, ctr_bus.centre_valid,
                     ctr_bus.last_centre, ctr_bus.points_dropped);
        end
      end
    end
  end

  // receiver: random stalls, plus long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      ctr_bus.ready <= 1'b0;
    end else
      ctr_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic test_directed();
    send_point(0, 0, 1);                       // too few points: empty marker
    for (int i = 0; i < 4; i++) send_point(100 + i, -50 - i, i == 3);
    write_reg(pcf_pkg::CFG_MIN_COUNT, 1);
    send_point(33554431, -33554432, 1);
    send_point(-33554432, 33554431, 1);
    send_point(-1, -1, 0);                     // negative tie rounds away from zero
    send_point(-2, -2, 1);
    send_point(0, 0, 0);                       // close centres collapse into one
    send_point(10, 10, 1);
    write_reg(pcf_pkg::CFG_MAX_DIST, 0);
    send_point(7, 7, 0);
    send_point(7, 7, 0);
    send_point(8, 7, 1);
    write_reg(pcf_pkg::CFG_MAX_DIST, 65535);
    send_point(33554431, 33554431, 0);
    send_point(-33554432, -33554432, 0);
    send_point(33554431, 33554431, 1);
    write_reg(pcf_pkg::CFG_MIN_COUNT, 0);
    send_point(5, 5, 1);
    write_reg(pcf_pkg::CFG_MIN_COUNT, 127);
    send_point(1, 1, 0);
    send_point(2, 2, 1);
    wait_drain();
  endtask

  task automatic test_overflow();
    write_reg(pcf_pkg::CFG_MAX_DIST, 200);
    write_reg(pcf_pkg::CFG_MIN_COUNT, 3);
    for (int i = 0; i < 70; i++)
      send_point((i % 4) * 100000 + $urandom_range(50), $urandom_range(50), i == 69);
    for (int i = 0; i < 65; i++)
      send_point(rand_coord(), rand_coord(), i == 64);
    wait_drain();
  endtask

  task automatic test_random();
    int n, md;
    for (int s = 0; s < 30; s++) begin
      if (s % 5 == 0) begin
        md = $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(1, 400);
        write_reg(pcf_pkg::CFG_MAX_DIST, md);
        write_reg(pcf_pkg::CFG_MIN_COUNT, $urandom_range(3) == 0 ? $urandom_range(127)
                                                                 : $urandom_range(1, 5));
        idle_pct = (s == 10) ? 0 : 18;
        sink_idle_pct = (s == 10) ? 0 : 18;
      end
      n = $urandom_range(1, 3);
      for (int b = 0; b < n; b++)
        send_blob($urandom_range(1, 5), $urandom_range(cur_max_dist / 2 + 1), 0);
      if ($urandom_range(2) == 0) send_point(rand_coord(), rand_coord(), 0);
      send_blob(1, 1, 1);
    end
    idle_pct = 18;
    sink_idle_pct = 18;
    wait_drain();
  endtask

  task automatic test_backpressure();
    write_reg(pcf_pkg::CFG_MAX_DIST, 64);
    write_reg(pcf_pkg::CFG_MIN_COUNT, 1);
    hold_cycles = 3000;
    for (int s = 0; s < 4; s++) begin
      send_blob(3, 30, 0);
      send_blob(2, 30, 1);
    end
    wait_drain();
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    pt_bus.valid = 0;
    pt_bus.point_x = '0;
    pt_bus.point_z = '0;
    pt_bus.last_point = 0;
    ctr_bus.ready = 0;
    errors = 0;
    set_cnt = 0;
    set_ovf = 0;
    cur_max_dist = 128;
    cur_min_count = 4;
    idle_pct = 18;
    sink_idle_pct = 18;
    hold_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random();
    test_backpressure();
    if (errors == 0 && centre_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
